// ===== rtl/mrrb_pkg.sv =====
// Shared constants, types and codes for the multi-reader ring buffer.
package mrrb_pkg;

  localparam int DEPTH   = 16;
  localparam int READERS = 4;
  localparam int DATA_W  = 32;

  localparam int WORD_W  = 32;
  localparam int SLOT_IW = 2;
  localparam int GIVEN_W = 2;
  localparam int STORE_W = (DATA_W < WORD_W) ? DATA_W : WORD_W;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SLOT_W  = (READERS > 1) ? $clog2(READERS) : 1;

  typedef enum logic [1:0] {
    OP_ATTACH = 2'd0,
    OP_DETACH = 2'd1,
    OP_PUSH   = 2'd2,
    OP_POP    = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic take;    // latch input item, launch store read
    logic commit;  // update state, load result register
  } cmd_t;

endpackage

// ===== rtl/mrrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mrrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/mrrb_ctrl.sv =====
// Controller: two-state sequencer and result-valid register.
module mrrb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output mrrb_pkg::cmd_t cmd
);
  import mrrb_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== rtl/mrrb_dp.sv =====
// Datapath: item latch, reader table, pointers, word store and result register.
module mrrb_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  mrrb_pkg::cmd_t                 cmd,
  input  logic [1:0]                     op,
  input  logic [mrrb_pkg::SLOT_IW-1:0]   reader_slot,
  input  logic [mrrb_pkg::WORD_W-1:0]    push_word,
  output logic                           ok,
  output logic [mrrb_pkg::GIVEN_W-1:0]   given_slot,
  output logic [mrrb_pkg::WORD_W-1:0]    pop_word
);
  import mrrb_pkg::*;

  localparam int AW = PTR_W + 2;

  // latched item
  op_t                op_q;
  logic [SLOT_IW-1:0] slot_q;
  logic [STORE_W-1:0] word_q;

  // buffer state
  logic [PTR_W-1:0]   wp;
  logic [PTR_W-1:0]   wp_next;
  logic [CNT_W-1:0]   used;
  logic [CNT_W-1:0]   used_next;
  logic [READERS-1:0] active;
  logic [READERS-1:0] active_next;
  logic [CNT_W-1:0]   lag      [READERS];
  logic [CNT_W-1:0]   lag_next [READERS];

  // result
  logic               ok_next;
  logic [GIVEN_W-1:0] given_next;
  logic [WORD_W-1:0]  pop_next;

  // store access
  logic [SLOT_W-1:0]  in_idx;
  logic [AW-1:0]      rd_sum;
  logic [PTR_W-1:0]   rd_addr;
  logic [STORE_W-1:0] rd_data;
  logic               store_we;

  // execute-phase decode
  logic [SLOT_W-1:0]  slot_idx;
  logic               slot_ok;
  logic [CNT_W-1:0]   lag_sel;
  logic               leads;
  logic               free_found;
  logic [SLOT_W-1:0]  free_idx;
  logic               push_ok;
  logic               pop_ok;

  // read address for a pop: wp - lag, modulo DEPTH
  assign in_idx  = SLOT_W'(reader_slot);
  assign rd_sum  = AW'(wp) + AW'(DEPTH) - AW'(lag[in_idx]);
  assign rd_addr = (rd_sum >= AW'(DEPTH)) ? PTR_W'(rd_sum - AW'(DEPTH)) : PTR_W'(rd_sum);

  assign store_we = cmd.commit && (op_q == OP_PUSH) && push_ok;

  mrrb_ram #(
    .WIDTH (STORE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (wp),
    .wdata (word_q),
    .re    (cmd.take),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q   <= op_t'(op);
      slot_q <= reader_slot;
      word_q <= push_word[STORE_W-1:0];
    end
    if (cmd.commit) begin
      ok         <= ok_next;
      given_slot <= given_next;
      pop_word   <= pop_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      used   <= '0;
      active <= '0;
      for (int r = 0; r < READERS; r++) begin
        lag[r] <= '0;
      end
    end else if (cmd.commit) begin
      wp     <= wp_next;
      used   <= used_next;
      active <= active_next;
      for (int r = 0; r < READERS; r++) begin
        lag[r] <= lag_next[r];
      end
    end
  end

  // slot checks, lowest free slot, strict-leader test
  always_comb begin
    slot_idx   = SLOT_W'(slot_q);
    slot_ok    = (32'(slot_q) < READERS) && active[slot_idx];
    lag_sel    = lag[slot_idx];
    free_found = 1'b0;
    free_idx   = '0;
    leads      = 1'b1;
    for (int r = READERS - 1; r >= 0; r--) begin
      if (!active[r]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(r);
      end
    end
    for (int r = 0; r < READERS; r++) begin
      if (active[r] && (SLOT_W'(r) != slot_idx) && (lag[r] >= lag_sel)) begin
        leads = 1'b0;
      end
    end
    push_ok = (used < CNT_W'(DEPTH));
    pop_ok  = slot_ok && (lag_sel != '0) && (used != '0);
  end

  always_comb begin
    wp_next     = wp;
    used_next   = used;
    active_next = active;
    for (int r = 0; r < READERS; r++) begin
      lag_next[r] = lag[r];
    end
    ok_next    = 1'b0;
    given_next = '0;
    pop_next   = '0;
    unique case (op_q)
      OP_ATTACH: begin
        if (free_found) begin
          active_next[free_idx] = 1'b1;
          lag_next[free_idx]    = '0;
          ok_next               = 1'b1;
          given_next            = GIVEN_W'(free_idx);
        end
      end
      OP_DETACH: begin
        if (slot_ok) begin
          active_next[slot_idx] = 1'b0;
          lag_next[slot_idx]    = '0;
          ok_next               = 1'b1;
        end
      end
      OP_PUSH: begin
        if (push_ok) begin
          wp_next   = (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + 1'b1;
          used_next = used + 1'b1;
          for (int r = 0; r < READERS; r++) begin
            if (active[r] && (lag[r] < CNT_W'(DEPTH))) begin
              lag_next[r] = lag[r] + 1'b1;
            end
          end
          ok_next = 1'b1;
        end
      end
      OP_POP: begin
        if (pop_ok) begin
          pop_next = WORD_W'(rd_data);
          if (leads) begin
            used_next = used - 1'b1;
          end
          lag_next[slot_idx] = lag_sel - 1'b1;
          ok_next            = 1'b1;
        end
      end
      default: ok_next = 1'b0;
    endcase
  end

endmodule

// ===== rtl/multi_reader_ring_buffer_top.sv =====
// A result is presented once the EXEC state commits it to the result register (later if the output stalls).
// One item at a time, limited by the word store's registered read port: read in the accept cycle,
//   state update and result load in EXEC, where the request channel stalls until the commit.
// A new item is taken while the previous result still waits in the output register.
// Reset (rst, synchronous): clears write pointer, used count, reader table and valids;
//   the word store itself is not cleared.
module multi_reader_ring_buffer_top (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   op,
  input  logic [mrrb_pkg::SLOT_IW-1:0] reader_slot,
  input  logic [mrrb_pkg::WORD_W-1:0]  push_word,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         ok,
  output logic [mrrb_pkg::GIVEN_W-1:0] given_slot,
  output logic [mrrb_pkg::WORD_W-1:0]  pop_word
);
  import mrrb_pkg::*;

  cmd_t cmd;

  // Sequencer: IDLE takes a transfer, EXEC commits once the result register is free.
  mrrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath: reader table, pointers, store RAM, and the result register.
  mrrb_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .op          (op),
    .reader_slot (reader_slot),
    .push_word   (push_word),
    .ok          (ok),
    .given_slot  (given_slot),
    .pop_word    (pop_word)
  );

endmodule
